@@ design/eds_pkg.sv @@
`timescale 1ns / 1ps
// eds_pkg: types, codes and constants of the exposure dither sequencer
// no dependencies; used by the interfaces and every module of the block
package eds_pkg;

  // field widths
  localparam int TICK_W     = 12;
  localparam int GAP_W      = 6;
  localparam int FRAME_W    = 14;
  localparam int STEP_W     = 3;
  localparam int DPH_W      = 10;
  localparam int SET_W      = 7;
  localparam int DIST_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // counter limits
  localparam logic [TICK_W-1:0]  TICKS_MAX  = {TICK_W{1'b1}};
  localparam logic [FRAME_W-1:0] FRAMES_MAX = {FRAME_W{1'b1}};
  localparam logic [TICK_W-1:0]  GAP_MIN    = TICK_W'(2);

  // register reset values
  localparam logic [TICK_W-1:0]  EXPOSURE_RST = TICK_W'(30);
  localparam logic [GAP_W-1:0]   GAP_RST      = GAP_W'(2);
  localparam logic [FRAME_W-1:0] FRAMES_RST   = FRAME_W'(1000);
  localparam logic [STEP_W-1:0]  STEP_RST     = STEP_W'(5);
  localparam logic [DPH_W-1:0]   EVERY_RST    = DPH_W'(2);
  localparam logic [SET_W-1:0]   PRESET_RST   = SET_W'(2);
  localparam logic [SET_W-1:0]   LIMIT_RST    = SET_W'(30);
  localparam logic [SET_W-1:0]   TIMEOUT_RST  = SET_W'(15);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_ABORT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_STOPPED   = 3'd0,
    PH_ARMED     = 3'd1,
    PH_EXPOSING  = 3'd2,
    PH_GAP       = 3'd3,
    PH_PRESETTLE = 3'd4,
    PH_SETTLING  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    GCMD_NONE    = 4'd0,
    GCMD_DITHER1 = 4'd3,
    GCMD_DITHER2 = 4'd4,
    GCMD_DITHER3 = 4'd5,
    GCMD_REQDIST = 4'd10,
    GCMD_DITHER4 = 4'd12,
    GCMD_DITHER5 = 4'd13
  } gcmd_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_SHUTTER_ERR = 3'd1,
    EV_COMPLETE    = 3'd2,
    EV_ABORTED     = 3'd3,
    EV_GUIDER_ERR  = 3'd4,
    EV_SETTLED     = 3'd5,
    EV_TIMEOUT     = 3'd6
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPOSURE = 3'd0,
    REG_GAP      = 3'd1,
    REG_FRAMES   = 3'd2,
    REG_STEP     = 3'd3,
    REG_EVERY    = 3'd4,
    REG_PRESET   = 3'd5,
    REG_LIMIT    = 3'd6,
    REG_TIMEOUT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0]  exposure_ticks;
    logic [GAP_W-1:0]   gap_ticks;
    logic [FRAME_W-1:0] frame_total;
    logic [STEP_W-1:0]  dither_step;
    logic [DPH_W-1:0]   dither_every;
    logic [SET_W-1:0]   presettle_ticks;
    logic [SET_W-1:0]   settle_limit;
    logic [SET_W-1:0]   settle_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [TICK_W-1:0]  ticks;
    logic [FRAME_W-1:0] frames;
    logic [DPH_W-1:0]   dphase;
    logic               dsent;
  } seq_state_t;

  typedef struct packed {
    action_t            act;
    gcmd_t              cmd;
    phase_t             phase;
    event_t             ev;
    logic [FRAME_W-1:0] frames;
    logic [TICK_W-1:0]  ticks;
  } seq_result_t;

  // dither size to guider move code, out-of-range sizes clamp
  function automatic gcmd_t dither_code(input logic [STEP_W-1:0] step);
    gcmd_t code;
    unique case (step)
      3'd0, 3'd1: code = GCMD_DITHER1;
      3'd2:       code = GCMD_DITHER2;
      3'd3:       code = GCMD_DITHER3;
      3'd4:       code = GCMD_DITHER4;
      default:    code = GCMD_DITHER5;
    endcase
    return code;
  endfunction

endpackage

@@ design/eds_if.sv @@
`timescale 1ns / 1ps
// eds channel interfaces: input item, result item and register write
// depends on eds_pkg for field widths
interface eds_item_if import eds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic              guider_linked;
  logic              shutter_ok;
  logic              guider_reply_ok;
  logic [DIST_W-1:0] guider_distance;

  modport source (output valid, operation, guider_linked, shutter_ok, guider_reply_ok,
                  guider_distance, input ready);
  modport sink (input valid, operation, guider_linked, shutter_ok, guider_reply_ok,
                guider_distance, output ready);
endinterface

interface eds_result_if import eds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         shutter_action;
  logic [3:0]         guider_command;
  logic [2:0]         phase;
  logic [2:0]         event_code;
  logic [FRAME_W-1:0] frame_index;
  logic [TICK_W-1:0]  tick_count;

  modport source (output valid, shutter_action, guider_command, phase, event_code,
                  frame_index, tick_count, input ready);
  modport sink (input valid, shutter_action, guider_command, phase, event_code,
                frame_index, tick_count, output ready);
endinterface

interface eds_cfg_if import eds_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/eds_cfg_regs.sv @@
`timescale 1ns / 1ps
// eds_cfg_regs: configuration register file of the sequencer
// depends on eds_pkg and eds_cfg_if
module eds_cfg_regs import eds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  eds_cfg_if.sink   cfg,
  output cfg_t      regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register writes, each truncated to its own width
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.exposure_ticks       <= EXPOSURE_RST;
      regs.gap_ticks            <= GAP_RST;
      regs.frame_total          <= FRAMES_RST;
      regs.dither_step          <= STEP_RST;
      regs.dither_every         <= EVERY_RST;
      regs.presettle_ticks      <= PRESET_RST;
      regs.settle_limit         <= LIMIT_RST;
      regs.settle_timeout_ticks <= TIMEOUT_RST;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        REG_EXPOSURE: regs.exposure_ticks       <= cfg.data[TICK_W-1:0];
        REG_GAP:      regs.gap_ticks            <= cfg.data[GAP_W-1:0];
        REG_FRAMES:   regs.frame_total          <= cfg.data[FRAME_W-1:0];
        REG_STEP:     regs.dither_step          <= cfg.data[STEP_W-1:0];
        REG_EVERY:    regs.dither_every         <= cfg.data[DPH_W-1:0];
        REG_PRESET:   regs.presettle_ticks      <= cfg.data[SET_W-1:0];
        REG_LIMIT:    regs.settle_limit         <= cfg.data[SET_W-1:0];
        REG_TIMEOUT:  regs.settle_timeout_ticks <= cfg.data[SET_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/eds_step.sv @@
`timescale 1ns / 1ps
// eds_step: next state and result of the sequencer for one beat
// depends on eds_pkg
module eds_step import eds_pkg::*; (
  input  cfg_t              regs,
  input  seq_state_t        cur,
  input  logic [1:0]        operation,
  input  logic              linked,
  input  logic              sh_ok,
  input  logic              gd_ok,
  input  logic [DIST_W-1:0] gd_dist,
  output seq_state_t        nxt,
  output seq_result_t       res
);

  logic [TICK_W-1:0]  ticks_inc;
  logic [FRAME_W-1:0] frames_inc;
  logic [DPH_W:0]     dphase_inc;
  logic               dither_wrap;
  logic               dither_due;
  logic               gap_end;
  logic               exp_end;
  logic               preset_end;
  logic               below_limit;
  logic               timed_out;
  action_t            act;
  gcmd_t              cmd;
  event_t             ev;

  // saturating counters and compares
  assign ticks_inc   = (cur.ticks == TICKS_MAX) ? cur.ticks : cur.ticks + 1'b1;
  assign frames_inc  = (cur.frames == FRAMES_MAX) ? cur.frames : cur.frames + 1'b1;
  assign dphase_inc  = {1'b0, cur.dphase} + 1'b1;
  assign dither_wrap = dphase_inc >= {1'b0, regs.dither_every};
  assign dither_due  = (cur.ticks == '0) && linked && dither_wrap;
  assign gap_end     = (ticks_inc >= {{(TICK_W-GAP_W){1'b0}}, regs.gap_ticks}) &&
                       (ticks_inc >= GAP_MIN);
  assign exp_end     = ticks_inc >= regs.exposure_ticks;
  assign preset_end  = ticks_inc >= {{(TICK_W-SET_W){1'b0}}, regs.presettle_ticks};
  assign below_limit = gd_dist < {{(DIST_W-SET_W){1'b0}}, regs.settle_limit};
  assign timed_out   = ticks_inc > {{(TICK_W-SET_W){1'b0}}, regs.settle_timeout_ticks};

  // phase sequencing
  always_comb begin
    nxt = cur;
    act = ACT_NONE;
    cmd = GCMD_NONE;
    ev  = EV_NONE;
    unique case (op_t'(operation))
      OP_START: begin
        nxt.phase = PH_ARMED;
        nxt.ticks = '0;
      end
      OP_ABORT: begin
        act       = ACT_RELEASE;
        nxt.phase = PH_STOPPED;
        ev        = EV_ABORTED;
      end
      OP_TICK: begin
        unique case (cur.phase)
          PH_ARMED: begin
            act        = ACT_PRESS;
            nxt.frames = '0;
            nxt.dphase = '0;
            if (sh_ok) begin
              nxt.phase = PH_EXPOSING;
              nxt.ticks = '0;
            end else begin
              nxt.phase = PH_STOPPED;
              ev        = EV_SHUTTER_ERR;
            end
          end
          PH_EXPOSING: begin
            nxt.ticks = ticks_inc;
            if (exp_end) begin
              act = ACT_RELEASE;
              if (sh_ok) begin
                nxt.phase = PH_GAP;
                nxt.ticks = '0;
                nxt.dsent = 1'b0;
              end else begin
                nxt.phase = PH_STOPPED;
                ev        = EV_SHUTTER_ERR;
              end
            end
          end
          PH_GAP: begin
            if (dither_due) begin
              cmd = dither_code(regs.dither_step);
            end
            if (dither_due && !gd_ok) begin
              // guider failure: retry on the next tick
              ev = EV_GUIDER_ERR;
            end else begin
              if (dither_due) begin
                nxt.dsent = 1'b1;
              end
              nxt.ticks = ticks_inc;
              if (gap_end) begin
                nxt.frames = frames_inc;
                nxt.dphase = dither_wrap ? '0 : dphase_inc[DPH_W-1:0];
                if (frames_inc >= regs.frame_total) begin
                  nxt.phase = PH_STOPPED;
                  ev        = EV_COMPLETE;
                end else if (dither_due || cur.dsent) begin
                  nxt.phase = PH_PRESETTLE;
                  nxt.ticks = '0;
                end else begin
                  act = ACT_PRESS;
                  if (sh_ok) begin
                    nxt.phase = PH_EXPOSING;
                    nxt.ticks = '0;
                  end else begin
                    nxt.phase = PH_STOPPED;
                    ev        = EV_SHUTTER_ERR;
                  end
                end
              end
            end
          end
          PH_PRESETTLE: begin
            nxt.ticks = ticks_inc;
            if (preset_end) begin
              nxt.phase = PH_SETTLING;
              nxt.ticks = '0;
            end
          end
          PH_SETTLING: begin
            nxt.ticks = ticks_inc;
            cmd       = GCMD_REQDIST;
            if (!gd_ok) begin
              ev = EV_GUIDER_ERR;
            end else if (below_limit || timed_out) begin
              act = ACT_PRESS;
              if (sh_ok) begin
                nxt.phase = PH_EXPOSING;
                nxt.ticks = '0;
                ev        = below_limit ? EV_SETTLED : EV_TIMEOUT;
              end else begin
                nxt.phase = PH_STOPPED;
                ev        = EV_SHUTTER_ERR;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result shows the state after the beat
  always_comb begin
    res.act    = act;
    res.cmd    = cmd;
    res.phase  = nxt.phase;
    res.ev     = ev;
    res.frames = nxt.frames;
    res.ticks  = nxt.ticks;
  end

endmodule

@@ design/exposure_dither_sequencer_unit.sv @@
`timescale 1ns / 1ps
// exposure_dither_sequencer_unit: top level of the exposure dither sequencer
// depends on eds_pkg, eds_if, eds_cfg_regs and eds_step
// the result of an accepted input beat is registered and shown in the cycle after it is taken
// throughput: one beat per cycle while the result side is ready; the result register frees in the cycle it is taken
// the sequencer state and the result register update on the same edge
// reset: phase stopped, counters zero, registers at their defaults, no result pending
module exposure_dither_sequencer_unit import eds_pkg::*; (
  input logic          clk,
  input logic          rst,
  eds_item_if.sink     item,
  eds_result_if.source result,
  eds_cfg_if.sink      cfg
);

  cfg_t        regs;
  seq_state_t  st;
  seq_state_t  st_next;
  seq_result_t step_res;
  seq_result_t out_res;
  logic        out_valid;
  logic        item_take;

  // configuration registers
  eds_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // per-beat sequencing logic
  eds_step u_step (
    .regs      (regs),
    .cur       (st),
    .operation (item.operation),
    .linked    (item.guider_linked),
    .sh_ok     (item.shutter_ok),
    .gd_ok     (item.guider_reply_ok),
    .gd_dist   (item.guider_distance),
    .nxt       (st_next),
    .res       (step_res)
  );

  // take a beat whenever the result register is free or draining
  assign item.ready = !out_valid || result.ready;
  assign item_take  = item.valid && item.ready;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase  <= PH_STOPPED;
      st.ticks  <= '0;
      st.frames <= '0;
      st.dphase <= '0;
      st.dsent  <= 1'b0;
    end else if (item_take) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_res <= step_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.shutter_action = out_res.act;
  assign result.guider_command = out_res.cmd;
  assign result.phase          = out_res.phase;
  assign result.event_code     = out_res.ev;
  assign result.frame_index    = out_res.frames;
  assign result.tick_count     = out_res.ticks;

  // abort always ends in stopped with the aborted event
  a_abort_stops: assert property (@(posedge clk) disable iff (rst)
    item_take && (item.operation == OP_ABORT) |=>
      out_valid && (out_res.phase == PH_STOPPED) && (out_res.ev == EV_ABORTED))
    else $error("abort did not stop the run");

  // a pending result matches the held state
  a_result_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.phase == st.phase) && (out_res.frames == st.frames) &&
                  (out_res.ticks == st.ticks))
    else $error("result and sequencer state disagree");

  // a press leads to exposing or to a shutter stop
  a_press_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.act == ACT_PRESS) |->
      (out_res.phase == PH_EXPOSING) || (out_res.phase == PH_STOPPED))
    else $error("press outside exposure start");

  // guider errors occur only in gap or settling and keep the phase
  a_guider_err_phase: assert property (@(posedge clk) disable iff (rst)
    item_take && (step_res.ev == EV_GUIDER_ERR) |->
      (st.phase == PH_GAP || st.phase == PH_SETTLING) && (st_next.phase == st.phase))
    else $error("guider error changed the phase");

endmodule

@@ verif/tb_exposure_dither_sequencer_unit.sv @@
`timescale 1ns / 1ps
// tb_exposure_dither_sequencer_unit: self-checking bench for the exposure dither sequencer
// depends on eds_pkg, the eds channel interfaces and exposure_dither_sequencer_unit
module tb_exposure_dither_sequencer_unit import eds_pkg::*; ();

  // operation code that the block treats like a tick while stopped
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 50;

  // tracks sequencer state and the results still owed by the block
  class exposure_ledger;
    cfg_t              regs;
    phase_t            run_phase;
    logic [TICK_W-1:0] phase_ticks;
    logic [FRAME_W-1:0] frames_done;
    logic [DPH_W-1:0]  dither_phase;
    bit                dither_sent;
    seq_result_t       due_results[$];
    int unsigned       errors;

    function new();
      regs.exposure_ticks       = EXPOSURE_RST;
      regs.gap_ticks            = GAP_RST;
      regs.frame_total          = FRAMES_RST;
      regs.dither_step          = STEP_RST;
      regs.dither_every         = EVERY_RST;
      regs.presettle_ticks      = PRESET_RST;
      regs.settle_limit         = LIMIT_RST;
      regs.settle_timeout_ticks = TIMEOUT_RST;
      run_phase    = PH_STOPPED;
      phase_ticks  = '0;
      frames_done  = '0;
      dither_phase = '0;
      dither_sent  = 1'b0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_EXPOSURE: regs.exposure_ticks       = value[TICK_W-1:0];
        REG_GAP:      regs.gap_ticks            = value[GAP_W-1:0];
        REG_FRAMES:   regs.frame_total          = value[FRAME_W-1:0];
        REG_STEP:     regs.dither_step          = value[STEP_W-1:0];
        REG_EVERY:    regs.dither_every         = value[DPH_W-1:0];
        REG_PRESET:   regs.presettle_ticks      = value[SET_W-1:0];
        REG_LIMIT:    regs.settle_limit         = value[SET_W-1:0];
        default:      regs.settle_timeout_ticks = value[SET_W-1:0];
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function logic [TICK_W-1:0] tick_bump(logic [TICK_W-1:0] v);
      return (v >= TICKS_MAX) ? v : v + 1'b1;
    endfunction

    // dither size clamps to 1..5 before it picks a move
    function gcmd_t move_code(logic [STEP_W-1:0] step);
      gcmd_t moves[5];
      int s;
      moves = '{GCMD_DITHER1, GCMD_DITHER2, GCMD_DITHER3, GCMD_DITHER4, GCMD_DITHER5};
      s = int'(step);
      if (s < 1) s = 1;
      if (s > 5) s = 5;
      return moves[s-1];
    endfunction

    function event_t shutter_press(bit ok, event_t good);
      if (!ok) begin
        run_phase = PH_STOPPED;
        return EV_SHUTTER_ERR;
      end
      run_phase   = PH_EXPOSING;
      phase_ticks = '0;
      return good;
    endfunction

    // advance the sequencer by one accepted input beat and queue its result
    function void note_item(logic [1:0] op, bit linked, bit sh_ok, bit gd_ok,
                            logic [DIST_W-1:0] distance);
      seq_result_t r;
      action_t act;
      gcmd_t cmd;
      event_t ev;
      bit retry;
      act   = ACT_NONE;
      cmd   = GCMD_NONE;
      ev    = EV_NONE;
      retry = 1'b0;
      if (op == OP_START) begin
        run_phase   = PH_ARMED;
        phase_ticks = '0;
      end else if (op == OP_ABORT) begin
        act       = ACT_RELEASE;
        run_phase = PH_STOPPED;
        ev        = EV_ABORTED;
      end else if (op == OP_TICK) begin
        case (run_phase)
          PH_ARMED: begin
            act          = ACT_PRESS;
            frames_done  = '0;
            dither_phase = '0;
            ev = shutter_press(sh_ok, EV_NONE);
          end
          PH_EXPOSING: begin
            phase_ticks = tick_bump(phase_ticks);
            if (phase_ticks >= regs.exposure_ticks) begin
              act = ACT_RELEASE;
              if (!sh_ok) begin
                run_phase = PH_STOPPED;
                ev        = EV_SHUTTER_ERR;
              end else begin
                run_phase   = PH_GAP;
                phase_ticks = '0;
                dither_sent = 1'b0;
              end
            end
          end
          PH_GAP: begin
            // dither goes out on the first gap tick of a due exposure
            if (phase_ticks == 0 && linked &&
                int'(dither_phase) + 1 >= int'(regs.dither_every)) begin
              cmd = move_code(regs.dither_step);
              if (!gd_ok) begin
                ev    = EV_GUIDER_ERR;
                retry = 1'b1;
              end else begin
                dither_sent = 1'b1;
              end
            end
            if (!retry) begin
              phase_ticks = tick_bump(phase_ticks);
              if (phase_ticks >= regs.gap_ticks && phase_ticks >= GAP_MIN) begin
                if (frames_done < FRAMES_MAX) frames_done = frames_done + 1'b1;
                if (int'(dither_phase) + 1 >= int'(regs.dither_every)) dither_phase = '0;
                else dither_phase = dither_phase + 1'b1;
                if (frames_done >= regs.frame_total) begin
                  run_phase = PH_STOPPED;
                  ev        = EV_COMPLETE;
                end else if (dither_sent) begin
                  run_phase   = PH_PRESETTLE;
                  phase_ticks = '0;
                end else begin
                  act = ACT_PRESS;
                  ev  = shutter_press(sh_ok, EV_NONE);
                end
              end
            end
          end
          PH_PRESETTLE: begin
            phase_ticks = tick_bump(phase_ticks);
            if (phase_ticks >= regs.presettle_ticks) begin
              run_phase   = PH_SETTLING;
              phase_ticks = '0;
            end
          end
          PH_SETTLING: begin
            phase_ticks = tick_bump(phase_ticks);
            cmd = GCMD_REQDIST;
            if (!gd_ok) begin
              ev = EV_GUIDER_ERR;
            end else if (distance < regs.settle_limit) begin
              act = ACT_PRESS;
              ev  = shutter_press(sh_ok, EV_SETTLED);
            end else if (phase_ticks > regs.settle_timeout_ticks) begin
              act = ACT_PRESS;
              ev  = shutter_press(sh_ok, EV_TIMEOUT);
            end
          end
          default: ;
        endcase
      end
      r.act    = act;
      r.cmd    = cmd;
      r.phase  = run_phase;
      r.ev     = ev;
      r.frames = frames_done;
      r.ticks  = phase_ticks;
      due_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [13:0] want, logic [13:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    // compare one result beat with the oldest owed result
    function void check_result(logic [1:0] act, logic [3:0] cmd, logic [2:0] ph,
                               logic [2:0] ev, logic [FRAME_W-1:0] fr,
                               logic [TICK_W-1:0] tk);
      seq_result_t want;
      if (due_results.size() == 0) begin
        $error("result beat with nothing owed: action %0d phase %0d event %0d", act, ph, ev);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("shutter_action", FRAME_W'(want.act), FRAME_W'(act));
      compare_field("guider_command", FRAME_W'(want.cmd), FRAME_W'(cmd));
      compare_field("phase", FRAME_W'(want.phase), FRAME_W'(ph));
      compare_field("event_code", FRAME_W'(want.ev), FRAME_W'(ev));
      compare_field("frame_index", want.frames, fr);
      compare_field("tick_count", FRAME_W'(want.ticks), FRAME_W'(tk));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  eds_item_if   item_bus ();
  eds_result_if result_bus ();
  eds_cfg_if    cfg_bus ();

  exposure_dither_sequencer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  exposure_ledger ledger = new();
  int idle_max = 8;
  bit hold_off_pending = 1'b0;

  always #4 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("exposure_dither_sequencer_unit regression: fail");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = $urandom_range(0, idle_max);
      if (hold_off_pending) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_pending = 1'b0;
      end
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      ledger.check_result(result_bus.shutter_action, result_bus.guider_command,
                          result_bus.phase, result_bus.event_code,
                          result_bus.frame_index, result_bus.tick_count);
    end
  end

  // offer one input beat after a random gap; valid stays high on return
  task automatic send_item(logic [1:0] op, bit linked, bit sh_ok, bit gd_ok,
                           logic [DIST_W-1:0] distance);
    int idle;
    idle = $urandom_range(0, idle_max);
    if (idle > 0) begin
      item_bus.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    item_bus.valid           <= 1'b1;
    item_bus.operation       <= op;
    item_bus.guider_linked   <= linked;
    item_bus.shutter_ok      <= sh_ok;
    item_bus.guider_reply_ok <= gd_ok;
    item_bus.guider_distance <= distance;
    do @(posedge clk); while (!item_bus.ready);
    ledger.note_item(op, linked, sh_ok, gd_ok, distance);
  endtask

  // stop offering and wait until every owed result has arrived
  task automatic drain();
    item_bus.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write all eight registers back to back
  task automatic program_regs(input cfg_t s);
    logic [CFG_DATA_W-1:0] word [8];
    word[REG_EXPOSURE] = CFG_DATA_W'(s.exposure_ticks);
    word[REG_GAP]      = CFG_DATA_W'(s.gap_ticks);
    word[REG_FRAMES]   = CFG_DATA_W'(s.frame_total);
    word[REG_STEP]     = CFG_DATA_W'(s.dither_step);
    word[REG_EVERY]    = CFG_DATA_W'(s.dither_every);
    word[REG_PRESET]   = CFG_DATA_W'(s.presettle_ticks);
    word[REG_LIMIT]    = CFG_DATA_W'(s.settle_limit);
    word[REG_TIMEOUT]  = CFG_DATA_W'(s.settle_timeout_ticks);
    for (int i = 0; i < 8; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= cfg_idx_t'(i);
      cfg_bus.data  <= word[i];
      do @(posedge clk); while (!cfg_bus.ready);
      ledger.set_reg(cfg_idx_t'(i), word[i]);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // short runs so that complete, dither and settle paths come up often
  function automatic cfg_t brisk_setting();
    cfg_t s;
    s.exposure_ticks       = TICK_W'($urandom_range(0, 6));
    s.gap_ticks            = GAP_W'($urandom_range(0, 5));
    s.frame_total          = FRAME_W'($urandom_range(0, 6));
    s.dither_step          = STEP_W'($urandom_range(0, 7));
    s.dither_every         = DPH_W'($urandom_range(0, 4));
    s.presettle_ticks      = SET_W'($urandom_range(0, 4));
    s.settle_limit         = SET_W'($urandom_range(0, 127));
    s.settle_timeout_ticks = SET_W'($urandom_range(0, 8));
    return s;
  endfunction

  // mostly well-formed runs: start when stopped, then ticks; some noise
  task automatic run_random(int count);
    int done;
    int r;
    logic [1:0] op;
    logic [DIST_W-1:0] distance;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (ledger.run_phase == PH_STOPPED) begin
        if (r < 75) op = OP_START;
        else if (r < 85) op = OP_TICK;
        else if (r < 93) op = OP_ABORT;
        else op = OP_UNUSED;
      end else begin
        if (r < 94) op = OP_TICK;
        else if (r < 96) op = OP_START;
        else if (r < 98) op = OP_ABORT;
        else op = OP_UNUSED;
      end
      // distance either anywhere or close to the settle threshold
      if ($urandom_range(0, 1)) distance = DIST_W'($urandom_range(0, 255));
      else distance = DIST_W'(ledger.regs.settle_limit + $urandom_range(0, 6) - 3);
      if (!(op == OP_UNUSED || (op == OP_TICK && ledger.run_phase == PH_STOPPED)))
        done++;
      send_item(op, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 97,
                $urandom_range(0, 99) < 90, distance);
    end
  endtask

  initial begin : stimulus
    cfg_t s;
    item_bus.valid           <= 1'b0;
    item_bus.operation       <= OP_START;
    item_bus.guider_linked   <= 1'b0;
    item_bus.shutter_ok      <= 1'b0;
    item_bus.guider_reply_ok <= 1'b0;
    item_bus.guider_distance <= '0;
    cfg_bus.valid            <= 1'b0;
    cfg_bus.index            <= REG_EXPOSURE;
    cfg_bus.data             <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, stopped-state corners and aborts
    send_item(OP_TICK, 0, 0, 0, 8'd0);
    send_item(OP_UNUSED, 1, 1, 1, 8'd255);
    send_item(OP_ABORT, 0, 0, 0, 8'd0);
    send_item(OP_START, 1, 1, 1, 8'd0);
    send_item(OP_START, 1, 1, 1, 8'd0);
    send_item(OP_TICK, 1, 1, 1, 8'd0);
    send_item(OP_ABORT, 1, 0, 1, 8'd0);
    drain();

    // directed: one-tick exposures, dither on every frame, two frames
    s = '{exposure_ticks: 12'd1, gap_ticks: 6'd0, frame_total: 14'd2, dither_step: 3'd0,
          dither_every: 10'd0, presettle_ticks: 7'd0, settle_limit: 7'd40,
          settle_timeout_ticks: 7'd1};
    program_regs(s);
    send_item(OP_START, 1, 1, 1, 8'd0);
    send_item(OP_TICK, 1, 0, 1, 8'd0);    // press fails
    send_item(OP_START, 1, 1, 1, 8'd0);
    send_item(OP_TICK, 1, 1, 1, 8'd0);
    send_item(OP_TICK, 1, 0, 1, 8'd0);    // release fails
    send_item(OP_START, 1, 1, 1, 8'd0);
    send_item(OP_TICK, 1, 1, 1, 8'd0);
    send_item(OP_TICK, 1, 1, 1, 8'd0);    // into the gap
    send_item(OP_TICK, 1, 1, 0, 8'd0);    // dither reply fails, retried
    send_item(OP_TICK, 1, 1, 1, 8'd0);
    send_item(OP_TICK, 1, 1, 1, 8'd0);    // gap ends, presettle
    send_item(OP_TICK, 1, 1, 1, 8'd0);    // zero presettle ends at once
    send_item(OP_TICK, 1, 1, 0, 8'd255);  // distance request fails
    send_item(OP_TICK, 1, 1, 1, 8'd10);   // settled
    send_item(OP_TICK, 1, 1, 1, 8'd0);
    send_item(OP_TICK, 0, 1, 1, 8'd0);    // no link, no dither
    send_item(OP_TICK, 0, 1, 1, 8'd0);    // run complete
    drain();

    // random with brisk settings
    program_regs(brisk_setting());
    run_random(120);
    drain();

    // every register at its low extreme
    program_regs('0);
    run_random(60);
    drain();

    // back-to-back beats against a long result hold-off
    idle_max = 0;
    hold_off_pending = 1'b1;
    program_regs(brisk_setting());
    run_random(100);
    drain();
    idle_max = 8;

    // high extremes with short exposures
    s = '{exposure_ticks: 12'd2, gap_ticks: 6'd63, frame_total: 14'd16383, dither_step: 3'd6,
          dither_every: 10'd1, presettle_ticks: 7'd127, settle_limit: 7'd127,
          settle_timeout_ticks: 7'd127};
    program_regs(s);
    run_random(120);
    drain();

    // every register at its high extreme
    s = '{exposure_ticks: 12'd4095, gap_ticks: 6'd63, frame_total: 14'd16383,
          dither_step: 3'd7, dither_every: 10'd1023, presettle_ticks: 7'd127,
          settle_limit: 7'd127, settle_timeout_ticks: 7'd127};
    program_regs(s);
    run_random(30);
    drain();

    repeat (3) begin
      program_regs(brisk_setting());
      run_random(110);
      drain();
    end

    if (ledger.errors == 0) begin
      $display("exposure_dither_sequencer_unit regression: pass");
    end else begin
      $display("exposure_dither_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule
